// File: src/wnpip_pkg.sv
// ----------------------------------------------------------------------------
// wnpip_pkg
// Shared types and constants for the winding-number point-in-polygon block.
// ----------------------------------------------------------------------------
package wnpip_pkg;

	localparam int COORD_W = 16;  // vertex / point coordinate width
	localparam int WIND_W  = 8;   // reported winding number width
	localparam int OUT_W   = 16;  // result tdata width (11 bits used)

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_poly;
		logic append;
		logic start_query;
		logic rd_en;
		logic load_result;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

// File: src/winding_number_point_in_polygon.sv
// ----------------------------------------------------------------------------
// winding_number_point_in_polygon
// Winding-number point-in-polygon tester over a stored vertex list.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser carries the operation (clear, append, query),
// tdata the x and y coordinate. Output stream (m_axis): one result per append
// or query; clear and the unused operation code give none.
// A clear takes effect on acceptance; an append goes to the FINISH state,
// which loads its result into the output register. A query reads the n
// stored vertices plus vertex 0 again through the store's single read port,
// one edge per cycle, into a three-stage edge pipeline (an empty polygon
// skips this walk); once the pipeline drains, FINISH loads the result and
// the next request is taken as soon as the result sits in that register.
// One request is in work at a time; a new one is accepted while a finished
// result still sits in the output register. If the receiver stalls, the
// block holds its next result until the register frees up, then goes on.
// Reset empties the polygon (vertex count 0) and drops any pending result;
// the vertex store itself is not cleared.
// ----------------------------------------------------------------------------
module winding_number_point_in_polygon #(
	parameter int MAX_VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // coord_x[15:0], coord_y[31:16]
	input  logic [1:0]  s_axis_tuser,   // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // inside_res[0], on_edge[1],
	                                    // winding_count[9:2], overflow[10]
);
	import wnpip_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	cmd_t                       cmd;
	status_t                    status;
	logic [AW-1:0]              rd_addr;
	logic [CW-1:0]              vertex_count;
	logic                       inside_res, on_edge, overflow;
	logic signed [WIND_W-1:0]   winding_count;

	wnpip_ctrl #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.op           (op_t'(s_axis_tuser)),
		.vertex_count (vertex_count),
		.status       (status),
		.cmd          (cmd),
		.rd_addr      (rd_addr)
	);

	wnpip_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.coord_x       (s_axis_tdata[COORD_W-1:0]),
		.coord_y       (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.vertex_count  (vertex_count),
		.status        (status),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.inside_res    (inside_res),
		.on_edge       (on_edge),
		.winding_count (winding_count),
		.overflow      (overflow)
	);

	assign m_axis_tdata = {(OUT_W - WIND_W - 3)'(0), overflow, winding_count,
	                       on_edge, inside_res};

endmodule

// File: src/wnpip_ram.sv
// ----------------------------------------------------------------------------
// wnpip_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wnpip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/wnpip_ctrl.sv
// ----------------------------------------------------------------------------
// wnpip_ctrl
// Controller: decodes requests, walks the vertex store for a query and
// hands finished results to the output register.
// ----------------------------------------------------------------------------
module wnpip_ctrl #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  wnpip_pkg::op_t                      op,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]   vertex_count,
	input  wnpip_pkg::status_t                  status,
	output wnpip_pkg::cmd_t                     cmd,
	output logic [$clog2(MAX_VERTICES)-1:0]     rd_addr
);
	import wnpip_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	state_t         state_q, state_d;
	logic [CW-1:0]  k_q;
	logic           accept;
	logic           last_rd;

	assign accept  = in_valid && (state_q == ST_IDLE);
	assign last_rd = (k_q == vertex_count);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_APPEND: state_d = ST_FINISH;
						OP_QUERY:  state_d = (vertex_count == '0) ? ST_FINISH : ST_WALK;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK: begin
				if (last_rd) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		// wrap edge reads vertex 0 again
		rd_addr  = last_rd ? '0 : k_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready         = 1'b1;
				cmd.clear_poly   = accept && (op == OP_CLEAR);
				cmd.append       = accept && (op == OP_APPEND);
				cmd.start_query  = accept && (op == OP_QUERY);
			end
			ST_WALK: begin
				cmd.rd_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_FINISH: begin
				cmd.load_result = status.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WALK) begin
				k_q <= k_q + CW'(1);
			end else begin
				k_q <= '0;
			end
		end
	end

endmodule

// File: src/wnpip_dp.sv
// ----------------------------------------------------------------------------
// wnpip_dp
// Datapath: vertex store, edge test pipeline (diffs, products, sign and
// accumulate) and the result register.
// ----------------------------------------------------------------------------
module wnpip_dp #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  wnpip_pkg::cmd_t                           cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0]           rd_addr,
	input  logic signed [wnpip_pkg::COORD_W-1:0]      coord_x,
	input  logic signed [wnpip_pkg::COORD_W-1:0]      coord_y,
	output logic [$clog2(MAX_VERTICES+1)-1:0]         vertex_count,
	output wnpip_pkg::status_t                        status,
	input  logic                                      out_ready,
	output logic                                      out_valid,
	output logic                                      inside_res,
	output logic                                      on_edge,
	output logic signed [wnpip_pkg::WIND_W-1:0]       winding_count,
	output logic                                      overflow
);
	import wnpip_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int DW = COORD_W + 1;
	localparam int PW = 2 * DW;
	localparam int WW = (CW + 2 > WIND_W + 1) ? CW + 2 : WIND_W + 1;
	localparam logic signed [WW-1:0] W_HI = WW'(2 ** (WIND_W - 1) - 1);
	localparam logic signed [WW-1:0] W_LO = -WW'(2 ** (WIND_W - 1));

	logic [CW-1:0]              count_q;
	logic                       full;
	logic [2*COORD_W-1:0]       rd_data;
	logic signed [COORD_W-1:0]  ax, ay, bx, by;
	logic signed [COORD_W-1:0]  px_q, py_q;
	logic                       ram_v_q, first_q;

	logic                       v_s1, box_s1, up_s1, dn_s1;
	logic signed [DW-1:0]       d_bax_s1, d_pay_s1, d_bay_s1, d_pax_s1;
	logic                       v_s2, box_s2, up_s2, dn_s2;
	logic signed [PW-1:0]       prod_a_s2, prod_b_s2;

	logic signed [PW:0]         cross_diff;
	logic                       c_zero, c_pos, c_neg;
	logic signed [WW-1:0]       wind_q, wind_sat;
	logic                       edge_q, is_query_q, ovf_q;

	assign full         = (count_q == CW'(MAX_VERTICES));
	assign vertex_count = count_q;

	wnpip_ram #(
		.WIDTH (2 * COORD_W),
		.DEPTH (MAX_VERTICES)
	) u_store (
		.clk   (clk),
		.we    (cmd.append && !full),
		.waddr (count_q[AW-1:0]),
		.wdata ({coord_y, coord_x}),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign bx = rd_data[COORD_W-1:0];
	assign by = rd_data[2*COORD_W-1:COORD_W];

	// polygon bookkeeping and query setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ram_v_q    <= 1'b0;
			first_q    <= 1'b0;
			is_query_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			ram_v_q <= cmd.rd_en;
			if (cmd.clear_poly) begin
				count_q <= '0;
			end else if (cmd.append && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.append) begin
				ovf_q      <= full;
				is_query_q <= 1'b0;
			end
			if (cmd.start_query) begin
				is_query_q <= 1'b1;
				first_q    <= 1'b1;
			end else if (ram_v_q) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (ram_v_q) begin
			ax <= bx;
			ay <= by;
		end
	end

	// stage 1: differences, bounding box and crossing direction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ram_v_q && !first_q;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		d_bax_s1 <= DW'(bx) - DW'(ax);
		d_pay_s1 <= DW'(py_q) - DW'(ay);
		d_bay_s1 <= DW'(by) - DW'(ay);
		d_pax_s1 <= DW'(px_q) - DW'(ax);
		box_s1   <= (px_q >= ((ax < bx) ? ax : bx)) && (px_q <= ((ax > bx) ? ax : bx)) &&
		            (py_q >= ((ay < by) ? ay : by)) && (py_q <= ((ay > by) ? ay : by));
		up_s1    <= (ay <= py_q) && (by > py_q);
		dn_s1    <= (ay > py_q) && (by <= py_q);
		// stage 2: cross product terms
		prod_a_s2 <= d_bax_s1 * d_pay_s1;
		prod_b_s2 <= d_bay_s1 * d_pax_s1;
		box_s2    <= box_s1;
		up_s2     <= up_s1;
		dn_s2     <= dn_s1;
	end

	// stage 3: sign of the cross product, accumulate
	assign cross_diff = (PW + 1)'(prod_a_s2) - (PW + 1)'(prod_b_s2);
	assign c_zero     = (cross_diff == '0);
	assign c_neg      = cross_diff[PW];
	assign c_pos      = !c_neg && !c_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wind_q <= '0;
			edge_q <= 1'b0;
		end else if (cmd.start_query) begin
			wind_q <= '0;
			edge_q <= 1'b0;
		end else if (v_s2) begin
			if (c_zero && box_s2) edge_q <= 1'b1;
			if (up_s2 && c_pos) begin
				wind_q <= wind_q + WW'(1);
			end else if (dn_s2 && c_neg) begin
				wind_q <= wind_q - WW'(1);
			end
		end
	end

	always_comb begin
		if (edge_q) begin
			wind_sat = '0;
		end else if (wind_q > W_HI) begin
			wind_sat = W_HI;
		end else if (wind_q < W_LO) begin
			wind_sat = W_LO;
		end else begin
			wind_sat = wind_q;
		end
	end

	assign status.pipe_busy = ram_v_q || v_s1 || v_s2;
	assign status.out_free  = !out_valid || out_ready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			inside_res    <= is_query_q && (wind_sat != '0);
			on_edge       <= is_query_q && edge_q;
			winding_count <= is_query_q ? wind_sat[WIND_W-1:0] : '0;
			overflow      <= !is_query_q && ovf_q;
		end
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the winding-number point-in-polygon tester.
// Polygons are built with clear and append requests. Query points are then
// sent at vertices, at edge midpoints, along vertex rows, near the centroid
// and anywhere in the plane. Each result is compared with a local winding-number
// predictor or, for directed rows marked checked, with a typed-in result. Both
// stream sides throttle at random; the output side also holds off for long stretches.
// ----------------------------------------------------------------------------
module testbench;
	import wnpip_pkg::*;

	localparam int MAX_VERT   = 64;
	localparam logic [1:0] OP_NONE = 2'd3;  // unused code, block drops it
	localparam int RAND_REQS  = 1150;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT = 20000;

	typedef struct packed {
		logic              inside_res;
		logic              on_edge;
		logic signed [7:0] winding_count;
		logic              overflow;
	} pip_res_t;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		bit                 checked;  // result typed in below
		pip_res_t           res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // coord_x[15:0], coord_y[31:16]
	logic [1:0]  s_axis_tuser;   // operation[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // inside_res[0], on_edge[1], winding_count[9:2],
	                             // overflow[10]

	// polygon as the predictor sees it
	longint    poly_x [MAX_VERT];
	longint    poly_y [MAX_VERT];
	int        poly_count;

	pip_res_t  due_results [$];
	stim_row_t stim_rows [$];

	int errors, n_reqs, n_results, n_appends, n_rejects, n_clears;
	int n_queries, n_inside, n_edge, n_holds, burst_left;
	bit hold_req;

	winding_number_point_in_polygon #(
		.MAX_VERTICES(MAX_VERT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #6 clk = ~clk;

	function automatic logic signed [15:0] c16(longint v);
		return v[15:0];
	endfunction

	function automatic int rnd(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic logic signed [15:0] any_coord();
		logic [31:0] u;
		u = $urandom;
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return u[15:0];
		endcase
	endfunction

	// Winding number of a point against the stored closed polygon.
	function automatic pip_res_t classify_point(longint px, longint py);
		pip_res_t r;
		longint ax, ay, bx, by, cr;
		int j, w;
		r = '0;
		w = 0;
		for (int i = 0; i < poly_count; i++) begin
			j = (i + 1 == poly_count) ? 0 : i + 1;
			ax = poly_x[i];
			ay = poly_y[i];
			bx = poly_x[j];
			by = poly_y[j];
			cr = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
			// a point on an edge counts as outside
			if (cr == 0 && px >= ((ax < bx) ? ax : bx) && px <= ((ax > bx) ? ax : bx)
					&& py >= ((ay < by) ? ay : by) && py <= ((ay > by) ? ay : by)) begin
				r.on_edge = 1'b1;
				return r;
			end
			if (ay <= py) begin
				if (by > py && cr > 0)
					w++;
			end else if (by <= py && cr < 0) begin
				w--;
			end
		end
		if (w > 127)
			w = 127;
		if (w < -128)
			w = -128;
		r.winding_count = w[7:0];
		r.inside_res    = (w != 0);
		return r;
	endfunction

	// Updates the polygon for one request; returns 1 if the request yields a result.
	function automatic bit apply_request(logic [1:0] op, logic signed [15:0] x,
			logic signed [15:0] y, output pip_res_t r);
		r = '0;
		case (op)
			OP_CLEAR: begin
				poly_count = 0;
				n_clears++;
				return 1'b0;
			end
			OP_APPEND: begin
				n_appends++;
				if (poly_count < MAX_VERT) begin
					poly_x[poly_count] = x;
					poly_y[poly_count] = y;
					poly_count++;
				end else begin
					r.overflow = 1'b1;
					n_rejects++;
				end
				return 1'b1;
			end
			OP_QUERY: begin
				r = classify_point(x, y);
				n_queries++;
				if (r.inside_res)
					n_inside++;
				if (r.on_edge)
					n_edge++;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic void add_row(logic [1:0] op, int x, int y, bit checked = 1'b0,
			logic ins = 1'b0, logic edg = 1'b0, int w = 0, logic ovf = 1'b0);
		stim_row_t row;
		row.op                = op;
		row.x                 = c16(x);
		row.y                 = c16(y);
		row.checked           = checked;
		row.res.inside_res    = ins;
		row.res.on_edge       = edg;
		row.res.winding_count = w[7:0];
		row.res.overflow      = ovf;
		stim_rows.push_back(row);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("%0t ns  mismatch, %s: got %0d, want %0d (result %0d)",
			$time, what, got, want, n_results);
	endtask

	// Sender: bursts of random length separated by random gaps.
	task automatic send_req(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y,
			bit checked = 1'b0, pip_res_t typed = '0);
		pip_res_t r;
		int gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : rnd(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? rnd(30, 80) : rnd(1, 10);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {y, x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		if (op != OP_NONE)
			n_reqs++;
		if (apply_request(op, x, y, r))
			due_results.push_back(checked ? typed : r);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	function automatic void pick_query_point(output logic signed [15:0] qx,
			output logic signed [15:0] qy);
		int k, j, t;
		longint sx, sy;
		if (poly_count == 0) begin
			qx = any_coord();
			qy = any_coord();
			return;
		end
		k  = rnd(0, poly_count - 1);
		j  = (k + 1 == poly_count) ? 0 : k + 1;
		qx = c16(poly_x[k]);
		qy = c16(poly_y[k]);
		case ($urandom_range(0, 6))
			0: ;  // the vertex itself
			1: begin
				qx = c16((poly_x[k] + poly_x[j]) >>> 1);
				qy = c16((poly_y[k] + poly_y[j]) >>> 1);
			end
			2: begin
				qx = c16(poly_x[k] + rnd(-3, 3));
				qy = c16(poly_y[k] + rnd(-3, 3));
			end
			3: qx = c16(poly_x[k] + rnd(-40, 40));  // same row as a vertex
			4: begin
				sx = 0;
				sy = 0;
				for (int i = 0; i < poly_count; i++) begin
					sx += poly_x[i];
					sy += poly_y[i];
				end
				qx = c16(sx / poly_count + rnd(-1, 1));
				qy = c16(sy / poly_count + rnd(-1, 1));
			end
			5: begin
				t  = rnd(0, 8);
				qx = c16(poly_x[k] + (poly_x[j] - poly_x[k]) * t / 8);
				qy = c16(poly_y[k] + (poly_y[j] - poly_y[k]) * t / 8 + rnd(-1, 1));
			end
			default: begin
				qx = any_coord();
				qy = any_coord();
			end
		endcase
	endfunction

	// One well-formed sequence: mostly a clear, then a vertex list, then a handful of queries.
	task automatic run_polygon_session();
		logic signed [15:0] lx [$];
		logic signed [15:0] ly [$];
		logic signed [15:0] x, y;
		int n, style, laps, sel;
		if ($urandom_range(0, 7) != 0)
			send_req(OP_CLEAR, any_coord(), any_coord());
		sel = rnd(0, 19);
		if (sel == 0)
			n = rnd(60, 70);
		else if (sel < 3)
			n = rnd(1, 2);
		else if (sel < 5)
			n = rnd(9, 24);
		else
			n = rnd(3, 8);
		style = rnd(0, 2);
		for (int i = 0; i < n; i++) begin
			case (style)
				0: begin
					x = c16(rnd(-12, 12));
					y = c16(rnd(-12, 12));
				end
				1: begin
					x = c16(2 * rnd(-400, 400));
					y = c16(2 * rnd(-400, 400));
				end
				default: begin
					x = any_coord();
					y = any_coord();
				end
			endcase
			lx.push_back(x);
			ly.push_back(y);
		end
		// walking the same loop again raises the winding number
		laps = (n <= 8 && $urandom_range(0, 5) == 0) ? rnd(2, 3) : 1;
		repeat (laps)
			for (int i = 0; i < n; i++)
				send_req(OP_APPEND, lx[i], ly[i]);
		repeat (rnd(3, 10)) begin
			pick_query_point(x, y);
			send_req(OP_QUERY, x, y);
		end
	endtask

	// Receiver: stall pattern of its own, plus long hold-offs on request.
	initial begin : rx_side
		int mode, len;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				n_holds++;
			end else begin
				mode = rnd(0, 3);
				len  = rnd(10, 80);
				for (int k = 0; k < len; k++) begin
					case (mode)
						0: m_axis_tready <= 1'b1;
						1: m_axis_tready <= ($urandom_range(0, 3) != 0);
						2: m_axis_tready <= (k % 4 == 3);
						default: m_axis_tready <= ($urandom_range(0, 1) == 1);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		pip_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			got.inside_res    = m_axis_tdata[0];
			got.on_edge       = m_axis_tdata[1];
			got.winding_count = m_axis_tdata[9:2];
			got.overflow      = m_axis_tdata[10];
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing outstanding", m_axis_tdata, 0);
			end else begin
				want = due_results.pop_front();
				if (got.inside_res !== want.inside_res)
					report_mismatch("inside_res", got.inside_res, want.inside_res);
				if (got.on_edge !== want.on_edge)
					report_mismatch("on_edge", got.on_edge, want.on_edge);
				if (got.winding_count !== want.winding_count)
					report_mismatch("winding_count", int'(got.winding_count),
						int'(want.winding_count));
				if (got.overflow !== want.overflow)
					report_mismatch("overflow", got.overflow, want.overflow);
			end
		end
	end

	initial begin : stimulus
		int rand_base, waited;
		bit mid_hold;
		logic [1:0] op;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		hold_req      = 1'b0;
		poly_count    = 0;
		burst_left    = 0;
		mid_hold      = 1'b0;

		// empty polygon, ignored code, full-range square, edges and corners
		add_row(OP_QUERY, 0, 0, 1);
		add_row(OP_NONE, 7, 7);
		add_row(OP_APPEND, -32768, -32768, 1);
		add_row(OP_APPEND, 32767, -32768, 1);
		add_row(OP_APPEND, 32767, 32767, 1);
		add_row(OP_APPEND, -32768, 32767, 1);
		add_row(OP_QUERY, 0, 0);
		add_row(OP_QUERY, 0, -32768, 1, 1'b0, 1'b1);
		add_row(OP_QUERY, 32767, 32767, 1, 1'b0, 1'b1);
		add_row(OP_QUERY, -32768, 0, 1, 1'b0, 1'b1);
		add_row(OP_QUERY, -1, -1);
		add_row(OP_CLEAR, 0, 0);
		add_row(OP_QUERY, 5, 5, 1);
		// one vertex, then two: degenerate edges
		add_row(OP_APPEND, 5, 5, 1);
		add_row(OP_QUERY, 5, 5, 1, 1'b0, 1'b1);
		add_row(OP_QUERY, 6, 5);
		add_row(OP_APPEND, -10, 5, 1);
		add_row(OP_QUERY, 0, 5, 1, 1'b0, 1'b1);
		add_row(OP_QUERY, 0, 6);
		add_row(OP_APPEND, 0, -20, 1);
		add_row(OP_QUERY, 0, 0);
		add_row(OP_QUERY, 0, -30);
		add_row(OP_NONE, -1, -1);
		add_row(OP_QUERY, -32768, 32767);
		add_row(OP_CLEAR, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_req(stim_rows[i].op, stim_rows[i].x, stim_rows[i].y,
				stim_rows[i].checked, stim_rows[i].res);
		drain_results();

		rand_base = n_reqs;
		for (int s = 0; n_reqs - rand_base < RAND_REQS; s++) begin
			if (s == 2)
				hold_req = 1'b1;
			if (!mid_hold && n_reqs - rand_base > RAND_REQS / 2) begin
				hold_req = 1'b1;
				mid_hold = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				// stray request: any code, any coordinates
				op = 2'(rnd(0, 3));
				send_req(op, any_coord(), any_coord());
			end else begin
				run_polygon_session();
			end
			if ($urandom_range(0, 5) == 0)
				drain_results();
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (due_results.size() != 0)
			report_mismatch("results still outstanding", due_results.size(), 0);
		repeat (MAX_VERT + 16) @(posedge clk);

		$display("run: %0d requests, %0d appends (%0d refused on a full store), %0d clears",
			n_reqs, n_appends, n_rejects, n_clears);
		$display("run: %0d queries (%0d inside, %0d on an edge), %0d long output holds",
			n_queries, n_inside, n_edge, n_holds);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#7200000;
		$display("timeout: bench did not finish");
		$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
src/wnpip_pkg.sv
src/wnpip_ram.sv
src/wnpip_ctrl.sv
src/wnpip_dp.sv
src/winding_number_point_in_polygon.sv
dv/testbench.sv
